// ===== sv/ttd_pkg.sv =====
package ttd_pkg;

    // Event codes carried on the opcode field.
    localparam logic [1:0] OP_X     = 2'd0;
    localparam logic [1:0] OP_Y     = 2'd1;
    localparam logic [1:0] OP_PRESS = 2'd2;
    localparam logic [1:0] OP_OTHER = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PRESSURE_LEVEL = 2'd0;
    localparam logic [1:0] CFG_TAP_TIME_LIMIT = 2'd1;
    localparam logic [1:0] CFG_MOTION_LIMIT   = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] PRESSURE_LEVEL_RESET = 16'd10;
    localparam logic [15:0] TAP_TIME_LIMIT_RESET = 16'd200;
    localparam logic [15:0] MOTION_LIMIT_RESET   = 16'd50;

    // What the back end has to do with one item.
    typedef enum logic [2:0] {
        KIND_IGNORE  = 3'd0,
        KIND_X       = 3'd1,
        KIND_Y       = 3'd2,
        KIND_PRESS   = 3'd3,
        KIND_RELEASE = 3'd4
    } ttd_kind_t;

    typedef struct packed {
        ttd_kind_t   kind;
        logic [15:0] value;
        logic [31:0] now_ms;
    } ttd_item_t;

    typedef struct packed {
        logic [15:0] pressure_level;
        logic [15:0] tap_time_limit_ms;
        logic [15:0] motion_limit;
    } ttd_cfg_t;

endpackage

// ===== sv/ttd_front.sv =====
module ttd_front (
    input  logic [1:0]         opcode,
    input  logic [15:0]        sample_value,
    input  logic [31:0]        now_ms,
    input  ttd_pkg::ttd_cfg_t  cfg,
    output ttd_pkg::ttd_item_t item
);

    logic press_hi;

    // Signed compare: a negative pressure always reads as a release.
    assign press_hi = $signed({sample_value[15], sample_value})
                      >= $signed({1'b0, cfg.pressure_level});

    always_comb begin
        item.value  = sample_value;
        item.now_ms = now_ms;
        case (opcode)
            ttd_pkg::OP_X:     item.kind = ttd_pkg::KIND_X;
            ttd_pkg::OP_Y:     item.kind = ttd_pkg::KIND_Y;
            ttd_pkg::OP_PRESS: item.kind = press_hi ? ttd_pkg::KIND_PRESS
                                                    : ttd_pkg::KIND_RELEASE;
            default:           item.kind = ttd_pkg::KIND_IGNORE;
        endcase
    end

endmodule

// ===== sv/ttd_queue.sv =====
module ttd_queue #(
    parameter int DEPTH = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ttd_pkg::ttd_item_t push_item,
    output logic               full,
    input  logic               pop,
    output ttd_pkg::ttd_item_t pop_item,
    output logic               not_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ttd_pkg::ttd_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/ttd_back.sv =====
module ttd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  ttd_pkg::ttd_cfg_t  cfg,
    input  logic               item_valid,
    input  ttd_pkg::ttd_item_t item,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_tap_detected,
    output logic               m_touch_down
);

    logic [15:0] last_x_reg, last_x_next;
    logic [15:0] last_y_reg, last_y_next;
    logic [15:0] origin_x_reg, origin_x_next;
    logic [15:0] origin_y_reg, origin_y_next;
    logic [31:0] press_time_reg, press_time_next;
    logic        seen_x_reg, seen_x_next;
    logic        seen_y_reg, seen_y_next;
    logic        origin_valid_reg, origin_valid_next;
    logic        active_reg, active_next;
    logic        has_moved_reg, has_moved_next;
    logic        m_valid_reg, m_valid_next;
    logic        tap_reg, tap_next;
    logic        down_reg;

    logic [15:0] new_x, new_y;
    logic [16:0] dx, dy, mag_x, mag_y;
    logic        drift;
    logic [31:0] elapsed;

    assign pop            = item_valid && (!m_valid_reg || m_ready);
    assign m_valid        = m_valid_reg;
    assign m_tap_detected = tap_reg;
    assign m_touch_down   = down_reg;

    // Coordinates as they stand after this item.
    assign new_x = (item.kind == ttd_pkg::KIND_X) ? item.value : last_x_reg;
    assign new_y = (item.kind == ttd_pkg::KIND_Y) ? item.value : last_y_reg;

    assign dx    = {new_x[15], new_x} - {origin_x_reg[15], origin_x_reg};
    assign dy    = {new_y[15], new_y} - {origin_y_reg[15], origin_y_reg};
    assign mag_x = dx[16] ? (17'd0 - dx) : dx;
    assign mag_y = dy[16] ? (17'd0 - dy) : dy;
    assign drift = (mag_x > {1'b0, cfg.motion_limit}) || (mag_y > {1'b0, cfg.motion_limit});

    assign elapsed = item.now_ms - press_time_reg;

    always_comb begin
        last_x_next       = last_x_reg;
        last_y_next       = last_y_reg;
        origin_x_next     = origin_x_reg;
        origin_y_next     = origin_y_reg;
        press_time_next   = press_time_reg;
        seen_x_next       = seen_x_reg;
        seen_y_next       = seen_y_reg;
        origin_valid_next = origin_valid_reg;
        active_next       = active_reg;
        has_moved_next    = has_moved_reg;
        tap_next          = 1'b0;
        case (item.kind)
            ttd_pkg::KIND_X, ttd_pkg::KIND_Y: begin
                last_x_next = new_x;
                last_y_next = new_y;
                seen_x_next = seen_x_reg || (item.kind == ttd_pkg::KIND_X);
                seen_y_next = seen_y_reg || (item.kind == ttd_pkg::KIND_Y);
                if (active_reg) begin
                    if (origin_valid_reg) begin
                        // Drift is only possible against an origin taken earlier.
                        if (drift) begin
                            has_moved_next = 1'b1;
                        end
                    end else if (seen_x_next && seen_y_next) begin
                        origin_x_next     = new_x;
                        origin_y_next     = new_y;
                        origin_valid_next = 1'b1;
                    end
                end
            end
            ttd_pkg::KIND_PRESS: begin
                if (!active_reg) begin
                    active_next       = 1'b1;
                    has_moved_next    = 1'b0;
                    press_time_next   = item.now_ms;
                    origin_valid_next = seen_x_reg && seen_y_reg;
                    if (seen_x_reg && seen_y_reg) begin
                        origin_x_next = last_x_reg;
                        origin_y_next = last_y_reg;
                    end
                end
            end
            ttd_pkg::KIND_RELEASE: begin
                if (active_reg) begin
                    tap_next = origin_valid_reg && !has_moved_reg
                               && (elapsed <= {16'd0, cfg.tap_time_limit_ms});
                    origin_x_next     = '0;
                    origin_y_next     = '0;
                    press_time_next   = '0;
                    origin_valid_next = 1'b0;
                    active_next       = 1'b0;
                    has_moved_next    = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_x_reg       <= '0;
            last_y_reg       <= '0;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            press_time_reg   <= '0;
            seen_x_reg       <= 1'b0;
            seen_y_reg       <= 1'b0;
            origin_valid_reg <= 1'b0;
            active_reg       <= 1'b0;
            has_moved_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                last_x_reg       <= last_x_next;
                last_y_reg       <= last_y_next;
                origin_x_reg     <= origin_x_next;
                origin_y_reg     <= origin_y_next;
                press_time_reg   <= press_time_next;
                seen_x_reg       <= seen_x_next;
                seen_y_reg       <= seen_y_next;
                origin_valid_reg <= origin_valid_next;
                active_reg       <= active_next;
                has_moved_reg    <= has_moved_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            tap_reg  <= tap_next;
            down_reg <= active_next;
        end
    end

endmodule

// ===== sv/touch_tap_detector.sv =====
// Channel     | Direction | Ports                                        | Moves
// ------------+-----------+----------------------------------------------+------------------
// s_ (events) | in        | s_valid s_ready s_opcode s_sample_value      | one sensor item
//             |           | s_now_ms                                     |
// m_ (result) | out       | m_valid m_ready m_tap_detected m_touch_down  | one result item
// cfg_        | in        | cfg_we cfg_index cfg_wdata                   | register write
//
// The block takes one item per clock while the queue has room and returns one result
// per item. An accepted item is written into the queue and, once the back end pops it,
// into the output register that drives the m_ port. The back end updates the whole
// touch state and loads the output register in the same cycle, which sets the sustained
// rate of one item per cycle while m_ready stays high. Reset (aresetn low at an edge)
// restores the register defaults and clears the touch state and the queue; a stall
// on the m_ side fills the queue and only then drops s_ready.
module touch_tap_detector #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [15:0] s_sample_value,
    input  logic [31:0] s_now_ms,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_tap_detected,
    output logic        m_touch_down,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    // Configuration registers. They are to be written only while the block is idle (the block
    // does not enforce this), so the front end may compare pressure against them before the queue.
    ttd_pkg::ttd_cfg_t  cfg_reg, cfg_next;

    ttd_pkg::ttd_item_t front_item;
    ttd_pkg::ttd_item_t queue_item;
    logic               queue_full;
    logic               queue_not_empty;
    logic               queue_pop;
    logic               push;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                ttd_pkg::CFG_PRESSURE_LEVEL: cfg_next.pressure_level    = cfg_wdata;
                ttd_pkg::CFG_TAP_TIME_LIMIT: cfg_next.tap_time_limit_ms = cfg_wdata;
                ttd_pkg::CFG_MOTION_LIMIT:   cfg_next.motion_limit      = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pressure_level    <= ttd_pkg::PRESSURE_LEVEL_RESET;
            cfg_reg.tap_time_limit_ms <= ttd_pkg::TAP_TIME_LIMIT_RESET;
            cfg_reg.motion_limit      <= ttd_pkg::MOTION_LIMIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // The input side only needs room in the queue.
    assign s_ready = !queue_full;
    assign push    = s_valid && s_ready;

    // Front end: decode the event kind and resolve press against release.
    ttd_front u_front (
        .opcode       (s_opcode),
        .sample_value (s_sample_value),
        .now_ms       (s_now_ms),
        .cfg          (cfg_reg),
        .item         (front_item)
    );

    // Short queue that lets the two halves stall independently.
    ttd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_item  (queue_item),
        .not_empty (queue_not_empty)
    );

    // Back end: touch state machine and the output register.
    ttd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .item_valid     (queue_not_empty),
        .item           (queue_item),
        .pop            (queue_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_tap_detected (m_tap_detected),
        .m_touch_down   (m_touch_down)
    );

endmodule

// ===== sv/ttd_checker.sv =====
module ttd_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_tap_detected,
    input logic m_touch_down
);

    // No result survives a reset.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A tap is reported only on the release that ends the touch.
    a_tap_ends_touch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tap_detected |-> !m_touch_down)
        else $error("tap reported while touch still down");

    // The input side backs up only behind a held result.
    a_backpressure_source: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tap_detected)
                                && $stable(m_touch_down))
        else $error("stalled result changed");

endmodule

bind touch_tap_detector ttd_checker u_ttd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_tap_detected (m_tap_detected),
    .m_touch_down   (m_touch_down)
);

// ===== tb/touch_tap_detector_tb.sv =====
module touch_tap_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Register index 3 decodes to nothing; writes there must be dropped.
    localparam logic [1:0] CFG_UNMAPPED = 2'd3;

    // Generous ceiling on the whole run, in ns.
    localparam int RUN_LIMIT_NS = 2_000_000;

    // One sensor event as it travels on the s_ channel.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] value;
        logic [31:0] now;
    } sensor_item_t;

    // One result item as it leaves on the m_ channel.
    typedef struct packed {
        logic tap;
        logic down;
    } touch_result_t;

    // Gesture tracking state kept alongside the block.
    typedef struct packed {
        logic [15:0] last_x;
        logic [15:0] last_y;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [31:0] press_time;
        logic        seen_x;
        logic        seen_y;
        logic        origin_valid;
        logic        active;
        logic        has_moved;
    } touch_state_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = ttd_pkg::OP_OTHER;
    logic [15:0] s_sample_value = '0;
    logic [31:0] s_now_ms = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_tap_detected;
    logic        m_touch_down;

    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = ttd_pkg::CFG_PRESSURE_LEVEL;
    logic [15:0] cfg_wdata = '0;

    touch_tap_detector u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_sample_value (s_sample_value),
        .s_now_ms       (s_now_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_tap_detected (m_tap_detected),
        .m_touch_down   (m_touch_down),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // The scoreboard's own copy of the configuration and the touch state.
    logic [15:0]   press_level = ttd_pkg::PRESSURE_LEVEL_RESET;
    logic [15:0]   tap_window  = ttd_pkg::TAP_TIME_LIMIT_RESET;
    logic [15:0]   drift_limit = ttd_pkg::MOTION_LIMIT_RESET;
    touch_state_t  trk = '0;

    sensor_item_t  sensor_fifo[$];     // items waiting to be driven
    touch_result_t predicted_taps[$];  // results owed by the block, oldest first
    int            items_queued = 0;
    int            failures = 0;

    // Generator-side memory of the stimulus, used to aim gestures.
    int            gen_x = 0;
    int            gen_y = 0;
    logic [31:0]   clock_ms = '0;

    // The start position is latched only while a touch is active and once
    // both axes have reported at least one coordinate.
    function automatic void grab_origin();
        if (!trk.active || trk.origin_valid || !trk.seen_x || !trk.seen_y)
            return;
        trk.origin_x = trk.last_x;
        trk.origin_y = trk.last_y;
        trk.origin_valid = 1'b1;
    endfunction

    // Any coordinate update during a touch may latch the start position and
    // then compares the drift on both axes against the motion limit.
    function automatic void follow_drift();
        int dx;
        int dy;
        if (!trk.active)
            return;
        grab_origin();
        if (!trk.origin_valid)
            return;
        dx = int'($signed(trk.last_x)) - int'($signed(trk.origin_x));
        dy = int'($signed(trk.last_y)) - int'($signed(trk.origin_y));
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        if (dx > int'(drift_limit) || dy > int'(drift_limit))
            trk.has_moved = 1'b1;
    endfunction

    // Advances the touch state by one item and returns the result it owes.
    function automatic touch_result_t apply_event(sensor_item_t it);
        touch_result_t res;
        logic [31:0]   elapsed;
        int            pressure;
        int            level;
        res = '0;
        pressure = $signed(it.value);
        level = int'(press_level);
        case (it.opcode)
            ttd_pkg::OP_X: begin
                trk.last_x = it.value;
                trk.seen_x = 1'b1;
                follow_drift();
            end
            ttd_pkg::OP_Y: begin
                trk.last_y = it.value;
                trk.seen_y = 1'b1;
                follow_drift();
            end
            ttd_pkg::OP_PRESS: begin
                // Signed compare: negative pressure is always a release.
                if (pressure >= level) begin
                    if (!trk.active) begin
                        trk.active = 1'b1;
                        trk.has_moved = 1'b0;
                        trk.origin_valid = 1'b0;
                        trk.press_time = it.now;
                        grab_origin();
                    end
                end else if (trk.active) begin
                    // Elapsed time wraps, so a clock that runs backwards
                    // gives a huge duration and never a tap.
                    elapsed = it.now - trk.press_time;
                    res.tap = trk.origin_valid && !trk.has_moved &&
                              elapsed <= {16'd0, tap_window};
                    trk.origin_x = '0;
                    trk.origin_y = '0;
                    trk.press_time = '0;
                    trk.origin_valid = 1'b0;
                    trk.active = 1'b0;
                    trk.has_moved = 1'b0;
                end
            end
            default: ;
        endcase
        res.down = trk.active;
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [15:0] clamp16(int v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    // A coordinate within the given spread of a base position.
    function automatic logic [15:0] coord_near(int base, int spread);
        return clamp16(base + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic int random_coord();
        if ($urandom_range(0, 7) == 0)
            return int'($urandom_range(0, 65535)) - 32768;
        return int'($urandom_range(0, 2000)) - 1000;
    endfunction

    // A pressure sample that counts as touch down, when one exists at all.
    function automatic logic [15:0] down_value();
        int level;
        int room;
        level = int'(press_level);
        if (level > 32767)
            return 16'($urandom);
        room = 32767 - level;
        if (room > 100)
            room = 100;
        if ($urandom_range(0, 3) == 0)
            return clamp16(level);
        return clamp16(level + int'($urandom_range(0, room)));
    endfunction

    // A pressure sample below the threshold.
    function automatic logic [15:0] up_value();
        int level;
        int hi;
        level = int'(press_level);
        hi = (level > 32768) ? 32767 : level - 1;
        if (level == 0 || $urandom_range(0, 3) == 0)
            return clamp16(-int'($urandom_range(1, 32768)));
        if ($urandom_range(0, 3) == 0)
            return clamp16(hi);
        return clamp16(int'($urandom_range(0, hi)));
    endfunction

    task automatic add_item(input logic [1:0] op, input logic [15:0] value,
                            input logic [31:0] now);
        sensor_item_t it;
        it.opcode = op;
        it.value = value;
        it.now = now;
        sensor_fifo.push_back(it);
        items_queued++;
    endtask

    // A register write takes effect at the next rising edge. The scoreboard
    // copy follows at once, which is safe because nothing is in flight.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            ttd_pkg::CFG_PRESSURE_LEVEL: press_level = value;
            ttd_pkg::CFG_TAP_TIME_LIMIT: tap_window = value;
            ttd_pkg::CFG_MOTION_LIMIT:   drift_limit = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Holds until every queued item has been taken and every result has
    // come back. The negative edge keeps this clear of the monitor's update.
    task automatic drain();
        do
            @(negedge aclk);
        while (sensor_fifo.size() != 0 || s_valid || predicted_taps.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // A full press, optional drift and release, with durations and drifts
    // chosen to fall on both sides of the current limits.
    task automatic queue_gesture();
        int          px;
        int          py;
        int          spread;
        int          n;
        logic [31:0] press_t;
        logic [31:0] rel_t;
        if ($urandom_range(0, 3) != 0) begin
            gen_x = random_coord();
            gen_y = random_coord();
            add_item(ttd_pkg::OP_X, clamp16(gen_x), clock_ms);
            add_item(ttd_pkg::OP_Y, clamp16(gen_y), clock_ms + 1);
        end
        px = gen_x;
        py = gen_y;
        spread = int'(drift_limit) + 2;
        if ($urandom_range(0, 3) == 0)
            spread = spread + int'($urandom_range(0, 200));
        press_t = clock_ms + $urandom_range(2, 20);
        add_item(ttd_pkg::OP_PRESS, down_value(), press_t);
        n = $urandom_range(0, 4);
        repeat (n) begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    gen_x = $signed(coord_near(px, spread));
                    add_item(ttd_pkg::OP_X, clamp16(gen_x), press_t);
                end
                2, 3: begin
                    gen_y = $signed(coord_near(py, spread));
                    add_item(ttd_pkg::OP_Y, clamp16(gen_y), press_t);
                end
                4: add_item(ttd_pkg::OP_OTHER, 16'($urandom), 32'($urandom));
                default: add_item(ttd_pkg::OP_PRESS, down_value(), press_t);
            endcase
        end
        case ($urandom_range(0, 9))
            0: rel_t = press_t + tap_window;
            1: rel_t = press_t + tap_window + 1;
            2: rel_t = press_t - $urandom_range(1, 50);
            3: rel_t = press_t + tap_window + $urandom_range(2, 1000);
            default: rel_t = press_t + $urandom_range(0, int'(tap_window));
        endcase
        add_item(ttd_pkg::OP_PRESS, up_value(), rel_t);
        clock_ms = rel_t + $urandom_range(1, 300);
    endtask

    // Anything at all, to reach every bit of every field.
    task automatic queue_noise();
        add_item(2'($urandom), 16'($urandom), 32'($urandom));
    endtask

    // Sender: one item held on the port until taken, random gaps between
    // items, and occasional stretches of back-to-back traffic.
    logic item_taken = 1'b0;
    int   tx_gap = 0;
    int   tx_count = 0;
    bit   tx_quiet = 1'b0;

    always @(negedge aclk) begin
        sensor_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !item_taken) begin
            // Still waiting for the handshake; hold everything.
        end else if (tx_gap > 0) begin
            tx_gap--;
            s_valid <= 1'b0;
        end else if (sensor_fifo.size() != 0) begin
            it = sensor_fifo.pop_front();
            s_opcode <= it.opcode;
            s_sample_value <= it.value;
            s_now_ms <= it.now;
            s_valid <= 1'b1;
            tx_count++;
            if (tx_count % 64 == 0)
                tx_quiet = ($urandom_range(0, 2) == 0);
            if (!tx_quiet && $urandom_range(0, 3) == 0)
                tx_gap = gap_len();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver: ready drops for random stretches, with quiet spells too.
    int rx_stall = 0;
    int rx_cycle = 0;
    bit rx_quiet = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            rx_cycle++;
            if (rx_cycle % 150 == 0)
                rx_quiet = ($urandom_range(0, 2) == 0);
            if (!rx_quiet && $urandom_range(0, 9) < 3)
                rx_stall = gap_len();
        end
    end

    // Monitor: every accepted item updates the scoreboard state and queues
    // the result it owes; every accepted result is checked against the
    // oldest one owed.
    always @(posedge aclk) begin
        sensor_item_t  it;
        touch_result_t want;
        if (!aresetn) begin
            item_taken <= 1'b0;
        end else begin
            item_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                it.opcode = s_opcode;
                it.value = s_sample_value;
                it.now = s_now_ms;
                predicted_taps.push_back(apply_event(it));
            end
            if (m_valid && m_ready) begin
                if (predicted_taps.size() == 0) begin
                    $error("result item with none outstanding: tap_detected %0b touch_down %0b",
                           m_tap_detected, m_touch_down);
                    failures++;
                end else begin
                    want = predicted_taps.pop_front();
                    if (m_tap_detected !== want.tap) begin
                        $error("tap_detected: expected %0b, actual %0b",
                               want.tap, m_tap_detected);
                        failures++;
                    end
                    if (m_touch_down !== want.down) begin
                        $error("touch_down: expected %0b, actual %0b",
                               want.down, m_touch_down);
                        failures++;
                    end
                end
            end
        end
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int target;
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, under the reset configuration (level 10, window
        // 200 ms, drift 50). The very first press comes before any
        // coordinate, so no start position exists and its release is no tap.
        add_item(ttd_pkg::OP_OTHER, 16'h7FFF, 32'd0);
        add_item(ttd_pkg::OP_PRESS, 16'd20, 32'd100);
        add_item(ttd_pkg::OP_PRESS, 16'd5, 32'd150);
        // Release with no touch active is ignored.
        add_item(ttd_pkg::OP_PRESS, 16'd0, 32'd160);
        // Press first, coordinates after: the start position is latched
        // when the second axis arrives.
        add_item(ttd_pkg::OP_PRESS, 16'd10, 32'd170);
        add_item(ttd_pkg::OP_X, 16'h8000, 32'd171);
        add_item(ttd_pkg::OP_Y, 16'h7FFF, 32'd172);
        // Pressure while already active changes nothing.
        add_item(ttd_pkg::OP_PRESS, 16'h7FFF, 32'd180);
        // Drift of exactly the limit is still a tap.
        add_item(ttd_pkg::OP_X, 16'h8032, 32'd190);
        add_item(ttd_pkg::OP_OTHER, 16'h0000, 32'hFFFF_FFFF);
        // Negative pressure releases; 200 ms is exactly the window.
        add_item(ttd_pkg::OP_PRESS, 16'hFFFF, 32'd370);
        // One millisecond past the window.
        add_item(ttd_pkg::OP_PRESS, 16'd10, 32'd2000);
        add_item(ttd_pkg::OP_PRESS, 16'd9, 32'd2201);
        // Drift one past the limit marks the touch as moved.
        add_item(ttd_pkg::OP_PRESS, 16'd10, 32'd3000);
        add_item(ttd_pkg::OP_Y, 16'h7FCC, 32'd3001);
        add_item(ttd_pkg::OP_PRESS, 16'd0, 32'd3010);
        // Time wraps through zero and is still a short tap.
        add_item(ttd_pkg::OP_PRESS, 16'd10, 32'hFFFF_FFF0);
        add_item(ttd_pkg::OP_PRESS, 16'h8000, 32'h0000_0010);
        // Clock runs backwards: huge elapsed time, no tap.
        add_item(ttd_pkg::OP_PRESS, 16'd10, 32'd5000);
        add_item(ttd_pkg::OP_PRESS, 16'd3, 32'd4999);
        // Opposite coordinate extremes and a zero-length tap.
        add_item(ttd_pkg::OP_X, 16'h7FFF, 32'd6000);
        add_item(ttd_pkg::OP_Y, 16'h8000, 32'd6001);
        add_item(ttd_pkg::OP_PRESS, 16'h7FFF, 32'd7000);
        add_item(ttd_pkg::OP_X, 16'h7FCD, 32'd7000);
        add_item(ttd_pkg::OP_PRESS, 16'h0000, 32'd7000);
        gen_x = 32767;
        gen_y = -32768;
        drain();

        // Random phases, each under its own configuration.
        for (int phase = 1; phase <= 8; phase++) begin
            case (phase)
                1: begin
                    write_reg(ttd_pkg::CFG_PRESSURE_LEVEL, 16'd0);
                    write_reg(ttd_pkg::CFG_TAP_TIME_LIMIT, 16'd0);
                    write_reg(ttd_pkg::CFG_MOTION_LIMIT, 16'd0);
                end
                2: begin
                    // Level above any signed sample: no touch ever starts.
                    write_reg(ttd_pkg::CFG_PRESSURE_LEVEL, 16'hFFFF);
                    write_reg(ttd_pkg::CFG_TAP_TIME_LIMIT, 16'hFFFF);
                    write_reg(ttd_pkg::CFG_MOTION_LIMIT, 16'hFFFF);
                end
                3: begin
                    write_reg(ttd_pkg::CFG_PRESSURE_LEVEL, 16'd32767);
                    write_reg(ttd_pkg::CFG_TAP_TIME_LIMIT, 16'hFFFF);
                    write_reg(ttd_pkg::CFG_MOTION_LIMIT, 16'hFFFF);
                end
                4: begin
                    write_reg(ttd_pkg::CFG_PRESSURE_LEVEL, 16'd32768);
                    write_reg(ttd_pkg::CFG_TAP_TIME_LIMIT, 16'($urandom_range(1, 400)));
                    write_reg(ttd_pkg::CFG_MOTION_LIMIT, 16'($urandom_range(0, 120)));
                end
                5: begin
                    write_reg(ttd_pkg::CFG_PRESSURE_LEVEL, 16'($urandom_range(1, 300)));
                    write_reg(ttd_pkg::CFG_TAP_TIME_LIMIT, 16'($urandom_range(1, 400)));
                    write_reg(ttd_pkg::CFG_MOTION_LIMIT, 16'($urandom_range(0, 120)));
                    // The unmapped index must leave every register alone.
                    write_reg(CFG_UNMAPPED, 16'h0000);
                end
                default: begin
                    write_reg(ttd_pkg::CFG_PRESSURE_LEVEL, 16'($urandom_range(0, 300)));
                    write_reg(ttd_pkg::CFG_TAP_TIME_LIMIT, 16'($urandom_range(0, 400)));
                    write_reg(ttd_pkg::CFG_MOTION_LIMIT, 16'($urandom_range(0, 120)));
                end
            endcase
            // Odd phases start just short of the millisecond wrap.
            if (phase % 2 == 1)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            else
                clock_ms = $urandom;
            target = items_queued + 103;
            while (items_queued < target) begin
                if ($urandom_range(0, 99) < 85)
                    queue_gesture();
                else
                    queue_noise();
            end
            drain();
        end

        repeat (10) @(negedge aclk);
        if (predicted_taps.size() != 0) begin
            $error("%0d result items never arrived", predicted_taps.size());
            failures++;
        end
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
